[design/cpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Shared sizes, result codes, policy codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int PAGES  = 32;
    localparam int IDX_W  = $clog2(PAGES);
    localparam int CNT_W  = $clog2(PAGES + 1);
    localparam int ID_W   = 8;
    localparam int PC_W   = 6;
    localparam int POL_W  = 2;
    localparam int STS_W  = 2;
    localparam int FRAG_W = 5;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 24;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGES - 1);

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_PRESENT  = 2'd1;
    localparam logic [STS_W-1:0] STS_NOFIT    = 2'd2;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd3;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_WORST = 2'd1;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Controller to datapath.
    typedef struct packed {
        logic             load;
        logic             scan;
        logic             apply;
        logic             emit;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[design/cpa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous page allocator controller
// Sequences the owner/run scan pass, the write-back pass and the result hand-off.
// ----------------------------------------------------------------------------
module cpa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    input  wire logic          i_req_action,
    output logic               o_req_ready,
    input  wire cpa_pkg::t_sts i_sts,
    output cpa_pkg::t_cmd      o_cmd
);
    import cpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    // A free request needs no placement scan.
                    n_state    = (i_req_action == ACT_FREE) ? S_APPLY : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_idx      = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule
`default_nettype wire

[design/cpa_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous page allocator datapath
// Page map, free-run tracking, write-back, fragment count and result register.
// ----------------------------------------------------------------------------
module cpa_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cpa_pkg::t_cmd              i_cmd,
    output cpa_pkg::t_sts                   o_sts,
    input  wire logic                       i_req_action,
    input  wire logic [cpa_pkg::ID_W-1:0]   i_req_owner,
    input  wire logic [cpa_pkg::PC_W-1:0]   i_req_count,
    input  wire logic                       i_cfg_we,
    input  wire logic [cpa_pkg::POL_W-1:0]  i_cfg_policy,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [cpa_pkg::OUT_W-1:0]       o_out_data
);
    import cpa_pkg::*;

    logic [ID_W-1:0]   r_map [PAGES];
    logic [POL_W-1:0]  r_fit_policy;

    logic              r_action;
    logic [ID_W-1:0]   r_owner;
    logic [PC_W-1:0]   r_count;

    logic              r_present;
    logic              r_have;
    logic [IDX_W-1:0]  r_best_start;
    logic [CNT_W-1:0]  r_best_len;
    logic [IDX_W-1:0]  r_run_start;
    logic [CNT_W-1:0]  r_run_len;

    logic              r_prev_used;
    logic [FRAG_W-1:0] r_frag;
    logic [CNT_W-1:0]  r_freed;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [ID_W-1:0]   page;
    logic              pg_free;
    logic [CNT_W-1:0]  cand_len;
    logic [IDX_W-1:0]  cand_start;
    logic              cand_end;
    logic              take;
    logic [CNT_W-1:0]  size;
    logic              alloc_ok;
    logic [CNT_W-1:0]  offset;
    logic              in_run;
    logic              freeing;
    logic [ID_W-1:0]   new_page;
    logic              new_used;
    logic [STS_W-1:0]  res_status;
    logic [IDX_W-1:0]  res_first;
    logic [CNT_W-1:0]  res_changed;

    assign page    = r_map[i_cmd.idx];
    assign pg_free = (page == '0);
    assign size    = CNT_W'(r_count);

    // A run is judged at the page where it ends: a used page after free ones,
    // or the last page of the map while still free.
    assign cand_len   = pg_free ? r_run_len + 1'b1 : r_run_len;
    assign cand_start = (pg_free && r_run_len == '0) ? i_cmd.idx : r_run_start;
    assign cand_end   = pg_free ? (i_cmd.idx == LAST_IDX) : (r_run_len != '0);

    always_comb begin
        unique case (r_fit_policy)
            POL_FIRST: take = !r_have && (cand_len >= size);
            POL_WORST: take = !r_have || (cand_len >= r_best_len);
            POL_BEST:  take = (cand_len >= size) && (!r_have || cand_len <= r_best_len);
            default:   take = 1'b0;
        endcase
    end

    assign alloc_ok = (r_action == ACT_ALLOC) && (r_owner != '0) && !r_present
                   && (r_fit_policy == POL_FIRST || r_fit_policy == POL_WORST
                       || r_fit_policy == POL_BEST)
                   && (size != '0) && (size <= CNT_W'(PAGES))
                   && r_have && (r_best_len >= size);

    assign offset   = CNT_W'(i_cmd.idx) - CNT_W'(r_best_start);
    assign in_run   = alloc_ok && (i_cmd.idx >= r_best_start) && (offset < size);
    assign freeing  = (r_action == ACT_FREE) && (r_owner != '0) && (page == r_owner);
    assign new_page = in_run ? r_owner : (freeing ? '0 : page);
    assign new_used = (new_page != '0);

    always_comb begin
        res_first   = '0;
        res_changed = '0;
        if (r_action == ACT_FREE) begin
            res_status  = (r_freed == '0) ? STS_NOTFOUND : STS_OK;
            res_changed = r_freed;
        end else if (r_owner == '0) begin
            res_status = STS_NOFIT;
        end else if (r_present) begin
            res_status = STS_PRESENT;
        end else if (!alloc_ok) begin
            res_status = STS_NOFIT;
        end else begin
            res_status  = STS_OK;
            res_first   = r_best_start;
            res_changed = size;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    // Page map; reset leaves every page free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAGES; k++) begin
                r_map[k] <= '0;
            end
        end else if (i_cmd.apply) begin
            r_map[i_cmd.idx] <= new_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy <= POL_FIRST;
        end else if (i_cfg_we) begin
            r_fit_policy <= i_cfg_policy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action     <= i_req_action;
            r_owner      <= i_req_owner;
            r_count      <= i_req_count;
            r_present    <= 1'b0;
            r_have       <= 1'b0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_prev_used  <= 1'b0;
            r_frag       <= '0;
            r_freed      <= '0;
        end else if (i_cmd.scan) begin
            if (page == r_owner) begin
                r_present <= 1'b1;
            end
            if (cand_end && take) begin
                r_have       <= 1'b1;
                r_best_start <= cand_start;
                r_best_len   <= cand_len;
            end
            r_run_start <= cand_start;
            r_run_len   <= pg_free ? cand_len : '0;
        end else if (i_cmd.apply) begin
            r_prev_used <= new_used;
            if (new_used && !r_prev_used) begin
                r_frag <= r_frag + 1'b1;
            end
            if (freeing) begin
                r_freed <= r_freed + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= OUT_W'({r_frag, res_changed, res_first, res_status});
        end
    end

endmodule
`default_nettype wire

[design/contiguous_page_allocator.sv]
`default_nettype none
// A free request makes one 32-page write pass; an allocate request makes one
// 32-page scan pass and then one 32-page write pass before its result is presented.
// Only one request is handled at a time: the next request is taken only after the
// result has been loaded into the output register, and that load waits while the
// output register still holds a result that has not been accepted.
// Reset (synchronous, active low) frees every page and selects first fit.
// ----------------------------------------------------------------------------
// Contiguous page allocator
// Places contiguous page runs per owner by first, worst or best fit, and frees an owner's pages.
// ----------------------------------------------------------------------------
module contiguous_page_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // owner_id[7:0], page_count[13:8], zero
    input  wire logic        i_s_axis_tuser,  // action[0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // status[1:0], first_page[6:2],
                                              // pages_changed[12:7], fragments[17:13]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data       // fit_policy[1:0]
);
    import cpa_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    assign o_s_axis_tready = req_ready;
    assign o_cfg_ready     = 1'b1;

    cpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_axis_tvalid),
        .i_req_action (i_s_axis_tuser),
        .o_req_ready  (req_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    cpa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_action (i_s_axis_tuser),
        .i_req_owner  (i_s_axis_tdata[7:0]),
        .i_req_count  (i_s_axis_tdata[13:8]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_policy (i_cfg_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_data   (o_m_axis_tdata)
    );

endmodule
`default_nettype wire
